@@ sv/mm4_pkg.sv @@
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// No dependencies; used by mm4_lane, matrix4x4_multiply and mm4_checker.
package mm4_pkg;

    localparam int DIM    = 4;
    localparam int DATA_W = 32;
    localparam int ROW_W  = 2;

    localparam logic [ROW_W-1:0] FIRST_ROW = 2'd0;
    localparam logic [ROW_W-1:0] LAST_ROW  = 2'd3;

    // one row or column of four Q16.16 elements, index = element number
    typedef logic [DIM-1:0][DATA_W-1:0] t_row;

    // input transfer: row i of A and row i of B
    typedef struct packed {
        logic signed [DATA_W-1:0] a_col0;
        logic signed [DATA_W-1:0] a_col1;
        logic signed [DATA_W-1:0] a_col2;
        logic signed [DATA_W-1:0] a_col3;
        logic signed [DATA_W-1:0] b_col0;
        logic signed [DATA_W-1:0] b_col1;
        logic signed [DATA_W-1:0] b_col2;
        logic signed [DATA_W-1:0] b_col3;
    } t_in;

    // output transfer: one row of C
    typedef struct packed {
        logic signed [DATA_W-1:0] c_col0;
        logic signed [DATA_W-1:0] c_col1;
        logic signed [DATA_W-1:0] c_col2;
        logic signed [DATA_W-1:0] c_col3;
        logic [ROW_W-1:0]         row_index;
        logic                     last;
    } t_out;

    // pipeline enables shared by all lanes
    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } t_lane_ctrl;

endpackage

@@ sv/mm4_lane.sv @@
// One column lane: four multipliers, then sum and saturate into an output register.
// Depends on mm4_pkg.
module mm4_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  mm4_pkg::t_lane_ctrl         i_ctrl,
    input  mm4_pkg::t_row               i_a_row,
    input  mm4_pkg::t_row               i_b_col,
    output logic signed [mm4_pkg::DATA_W-1:0] o_c
);

    localparam int PROD_W = 2 * mm4_pkg::DATA_W;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0]          r_prod [mm4_pkg::DIM];
    logic signed [PROD_W-1:0]          n_prod [mm4_pkg::DIM];
    logic signed [SUM_W-1:0]           sum;
    logic signed [mm4_pkg::DATA_W-1:0] n_c;
    logic signed [mm4_pkg::DATA_W-1:0] r_c;

    // stage 1: full products, scaled back to Q16.16 (floor)
    always_comb begin
        for (int k = 0; k < mm4_pkg::DIM; k++) begin
            n_prod[k] = ($signed(i_a_row[k]) * $signed(i_b_col[k])) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_prod) begin
            r_prod <= n_prod;
        end
    end

    // stage 2: exact sum, then clamp to 32 bits
    always_comb begin
        sum = '0;
        for (int k = 0; k < mm4_pkg::DIM; k++) begin
            sum = sum + SUM_W'(r_prod[k]);
        end
        if (!sum[SUM_W-1] && (sum[SUM_W-2:mm4_pkg::DATA_W-1] != '0)) begin
            n_c = {1'b0, {(mm4_pkg::DATA_W-1){1'b1}}};
        end else if (sum[SUM_W-1] && (sum[SUM_W-2:mm4_pkg::DATA_W-1] != '1)) begin
            n_c = {1'b1, {(mm4_pkg::DATA_W-1){1'b0}}};
        end else begin
            n_c = sum[mm4_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_sum) begin
            r_c <= n_c;
        end
    end

    assign o_c = r_c;

endmodule

@@ sv/matrix4x4_multiply.sv @@
// Top level of the 4x4 Q16.16 matrix multiplier: row stores, sequencer, four lanes.
// Depends on mm4_pkg and mm4_lane.
//
//  channel | handshake         | payload         | direction
//  --------+-------------------+-----------------+----------
//  input   | i_valid / o_ready | i_data (t_in)   | in
//  output  | o_valid / i_ready | o_data (t_out)  | out
//
// Four input transfers load rows 0..3 of A and B, one per cycle while i_valid is held.
// After row 3 the sequencer issues the four rows of C to the four column lanes,
// one per cycle unless the output stalls; each row passes the multipliers, then the adder.
// Input is held off from row 3 until the last row of C has entered the multipliers.
// Output stalls back up through the adder and multiplier stages; reset is
// synchronous, active low, and clears the sequencer and valid flags.
module matrix4x4_multiply #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mm4_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output mm4_pkg::t_out o_data
);

    typedef enum logic [1:0] {
        S_LOAD  = 2'b01,
        S_ISSUE = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    logic [mm4_pkg::ROW_W-1:0]  r_row_cnt, n_row_cnt;
    logic [mm4_pkg::ROW_W-1:0]  r_iss_row, n_iss_row;
    logic                       r_p_vld, n_p_vld;
    logic [mm4_pkg::ROW_W-1:0]  r_p_row, n_p_row;
    logic                       r_o_vld, n_o_vld;
    logic [mm4_pkg::ROW_W-1:0]  r_o_row, n_o_row;

    mm4_pkg::t_row              r_a_rows [mm4_pkg::DIM];
    mm4_pkg::t_row              r_b_rows [mm4_pkg::DIM];
    mm4_pkg::t_row              b_cols   [mm4_pkg::DIM];
    logic signed [mm4_pkg::DATA_W-1:0] lane_c [mm4_pkg::DIM];

    mm4_pkg::t_lane_ctrl        ctrl;
    logic                       in_xfer;
    logic                       out_free;
    logic                       prod_free;

    // handshake and stage enables
    always_comb begin
        in_xfer        = i_valid && (r_state == S_LOAD);
        out_free       = !r_o_vld || i_ready;
        ctrl.load_sum  = r_p_vld && out_free;
        prod_free      = !r_p_vld || ctrl.load_sum;
        ctrl.load_prod = (r_state == S_ISSUE) && prod_free;
    end

    // sequencer and valid flags
    always_comb begin
        n_state   = r_state;
        n_row_cnt = r_row_cnt;
        n_iss_row = r_iss_row;
        n_p_vld   = r_p_vld;
        n_p_row   = r_p_row;
        n_o_vld   = r_o_vld;
        n_o_row   = r_o_row;

        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    n_row_cnt = r_row_cnt + 1'b1;
                    if (r_row_cnt == mm4_pkg::LAST_ROW) begin
                        n_state   = S_ISSUE;
                        n_iss_row = mm4_pkg::FIRST_ROW;
                    end
                end
            end
            S_ISSUE: begin
                if (ctrl.load_prod) begin
                    n_iss_row = r_iss_row + 1'b1;
                    if (r_iss_row == mm4_pkg::LAST_ROW) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (ctrl.load_prod) begin
            n_p_vld = 1'b1;
            n_p_row = r_iss_row;
        end else if (ctrl.load_sum) begin
            n_p_vld = 1'b0;
        end

        if (ctrl.load_sum) begin
            n_o_vld = 1'b1;
            n_o_row = r_p_row;
        end else if (i_ready) begin
            n_o_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_row_cnt <= '0;
            r_iss_row <= '0;
            r_p_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row_cnt <= n_row_cnt;
            r_iss_row <= n_iss_row;
            r_p_vld   <= n_p_vld;
            r_o_vld   <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_row <= n_p_row;
        r_o_row <= n_o_row;
    end

    // row stores, written at the incoming row number
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_rows[r_row_cnt] <= {i_data.a_col3, i_data.a_col2,
                                    i_data.a_col1, i_data.a_col0};
            r_b_rows[r_row_cnt] <= {i_data.b_col3, i_data.b_col2,
                                    i_data.b_col1, i_data.b_col0};
        end
    end

    // column j of B for lane j
    always_comb begin
        for (int j = 0; j < mm4_pkg::DIM; j++) begin
            for (int k = 0; k < mm4_pkg::DIM; k++) begin
                b_cols[j][k] = r_b_rows[k][j];
            end
        end
    end

    // one lane per column of C
    for (genvar j = 0; j < mm4_pkg::DIM; j++) begin : g_lane
        mm4_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_a_row (r_a_rows[r_iss_row]),
            .i_b_col (b_cols[j]),
            .o_c     (lane_c[j])
        );
    end

    // merge lane results into the output transfer
    always_comb begin
        o_data.c_col0    = lane_c[0];
        o_data.c_col1    = lane_c[1];
        o_data.c_col2    = lane_c[2];
        o_data.c_col3    = lane_c[3];
        o_data.row_index = r_o_row;
        o_data.last      = (r_o_row == mm4_pkg::LAST_ROW);
    end

    assign o_ready = (r_state == S_LOAD);
    assign o_valid = r_o_vld;

endmodule

@@ sv/mm4_checker.sv @@
// Port-level checks for matrix4x4_multiply, attached by bind.
// Depends on mm4_pkg.
module mm4_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input mm4_pkg::t_out o_data
);

    // no result straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // last marks row 3 only
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last == (o_data.row_index == mm4_pkg::LAST_ROW)))
        else $error("last flag does not match row index");

    // while row 0 is pending, rows 2 and 3 are still to be issued
    a_row0_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.row_index == mm4_pkg::FIRST_ROW) |-> !o_ready)
        else $error("input taken while product rows outstanding");

endmodule

bind matrix4x4_multiply mm4_checker u_mm4_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

@@ verif/tb_matrix4x4_multiply.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for matrix4x4_multiply: directed and random row transfers,
// with each product row checked against an in-bench Q16.16 matrix product.
// Depends on mm4_pkg and the matrix4x4_multiply RTL.
module tb_matrix4x4_multiply;

    localparam int DATA_W       = mm4_pkg::DATA_W;
    localparam int DIM          = mm4_pkg::DIM;
    localparam int ROW_W        = mm4_pkg::ROW_W;

    localparam int FRAC         = 16;
    localparam int IDLE_PCT     = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RAND_GROUPS  = 80;

    // calm window: no idling on either side
    localparam int CALM_FROM = 200;
    localparam int CALM_TO   = 450;

    localparam logic [DATA_W-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_M_ONE = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] Q_HALF  = 32'h0000_8000;
    localparam logic [DATA_W-1:0] Q_LSB   = 32'h0000_0001;
    localparam logic [DATA_W-1:0] Q_M_LSB = 32'hFFFF_FFFF;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    mm4_pkg::t_in   i_data  = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    mm4_pkg::t_out  o_data;

    mm4_pkg::t_in   rows_to_send [$];
    mm4_pkg::t_out  expected_c_rows [$];

    // running copy of the two matrices and the row being filled
    logic [DATA_W-1:0] mat_a [DIM][DIM];
    logic [DATA_W-1:0] mat_b [DIM][DIM];
    logic [ROW_W-1:0]  fill_row = mm4_pkg::FIRST_ROW;

    int unsigned mismatches = 0;
    int unsigned cycle_no   = 0;
    int unsigned quiet      = 0;
    logic        calm;

    matrix4x4_multiply #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

    // one element of C: truncated products summed exactly, then saturated
    function automatic logic [DATA_W-1:0] dot_q16(int row, int col);
        logic signed [63:0] prod;
        logic signed [65:0] acc;
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
            prod = $signed(mat_a[row][k]) * $signed(mat_b[k][col]);
            acc  = acc + (prod >>> FRAC);
        end
        if (acc > 66'sd2147483647)
            return Q_MAX;
        if (acc < -66'sd2147483648)
            return Q_MIN;
        return acc[DATA_W-1:0];
    endfunction

    // store one row pair; the fourth row of a group yields the four rows of C
    function automatic void absorb_row(mm4_pkg::t_in item);
        mm4_pkg::t_out c_row;
        mat_a[fill_row] = '{item.a_col0, item.a_col1, item.a_col2, item.a_col3};
        mat_b[fill_row] = '{item.b_col0, item.b_col1, item.b_col2, item.b_col3};
        if (fill_row != mm4_pkg::LAST_ROW) begin
            fill_row = fill_row + 1'b1;
        end else begin
            fill_row = mm4_pkg::FIRST_ROW;
            for (int i = 0; i < DIM; i++) begin
                c_row.c_col0    = dot_q16(i, 0);
                c_row.c_col1    = dot_q16(i, 1);
                c_row.c_col2    = dot_q16(i, 2);
                c_row.c_col3    = dot_q16(i, 3);
                c_row.row_index = ROW_W'(i);
                c_row.last      = (ROW_W'(i) == mm4_pkg::LAST_ROW);
                expected_c_rows.push_back(c_row);
            end
        end
    endfunction

    task automatic queue_rows(input logic [DATA_W-1:0] a0, a1, a2, a3, b0, b1, b2, b3);
        mm4_pkg::t_in item;
        item = '{a0, a1, a2, a3, b0, b1, b2, b3};
        rows_to_send.push_back(item);
    endtask

    function automatic logic [DATA_W-1:0] pick_extreme();
        case ($urandom_range(5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return Q_M_LSB;
            4:       return Q_ONE;
            default: return Q_M_ONE;
        endcase
    endfunction

    // style 0: within +/-4.0, 1: full range, 2: mix with extremes
    function automatic logic [DATA_W-1:0] pick_q16(int style);
        int roll;
        roll = $urandom_range(99);
        if (style == 1)
            return $urandom();
        if (style == 2 && roll < 20)
            return pick_extreme();
        if (style == 2 && roll >= 60)
            return $urandom();
        return DATA_W'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch, %s", $realtime, what);
    endtask

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // stimulus, reset and end of run
    initial begin
        logic [DATA_W-1:0] lsb_rows [DIM];
        logic [DATA_W-1:0] v;
        int style;
        lsb_rows = '{Q_M_LSB, Q_LSB, '0, Q_HALF};

        // identity times random B gives B back
        for (int r = 0; r < DIM; r++)
            queue_rows(r == 0 ? Q_ONE : '0, r == 1 ? Q_ONE : '0,
                       r == 2 ? Q_ONE : '0, r == 3 ? Q_ONE : '0,
                       $urandom(), $urandom(), $urandom(), $urandom());
        // extremes against full-scale positive B, then full-scale negative B
        for (int r = 0; r < DIM; r++) begin
            v = r[0] ? Q_MIN : Q_MAX;
            queue_rows(v, v, v, v, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        end
        for (int r = 0; r < DIM; r++) begin
            v = r[0] ? Q_MIN : Q_MAX;
            queue_rows(v, v, v, v, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        end
        // truncation of tiny products toward minus infinity
        for (int r = 0; r < DIM; r++)
            queue_rows(lsb_rows[r], lsb_rows[r], lsb_rows[r], lsb_rows[r],
                       Q_LSB, Q_LSB, Q_LSB, Q_LSB);
        // sums just at and just past either saturation bound
        queue_rows(Q_MAX, '0, '0, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_rows(Q_MAX, Q_ONE, '0, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_rows(Q_MIN, '0, '0, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_rows(Q_MIN, Q_M_ONE, '0, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);

        // random whole groups, mostly small values that keep clear of saturation
        for (int g = 0; g < RAND_GROUPS; g++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: style = 0;
                5, 6:          style = 1;
                default:       style = 2;
            endcase
            for (int r = 0; r < DIM; r++)
                queue_rows(pick_q16(style), pick_q16(style), pick_q16(style),
                           pick_q16(style), pick_q16(style), pick_q16(style),
                           pick_q16(style), pick_q16(style));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample away from the active edge
        while (rows_to_send.size() != 0 || i_valid || expected_c_rows.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_matrix4x4_multiply passed");
        else
            $display("tb_matrix4x4_multiply failed");
        $finish;
    end

    // driver: predict on each input transfer, then present the next row pair
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                absorb_row(i_data);
            if (!i_valid || o_ready) begin
                if (rows_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    i_data  <= rows_to_send.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each output transfer with the oldest predicted row
    always @(posedge i_clk) begin
        mm4_pkg::t_out want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_c_rows.size() == 0) begin
                    report_mismatch($sformatf("unexpected row %0d of C", o_data.row_index));
                end else begin
                    want = expected_c_rows.pop_front();
                    if (o_data.c_col0 !== want.c_col0)
                        report_mismatch($sformatf("row %0d c_col0 got %h want %h",
                                        want.row_index, o_data.c_col0, want.c_col0));
                    if (o_data.c_col1 !== want.c_col1)
                        report_mismatch($sformatf("row %0d c_col1 got %h want %h",
                                        want.row_index, o_data.c_col1, want.c_col1));
                    if (o_data.c_col2 !== want.c_col2)
                        report_mismatch($sformatf("row %0d c_col2 got %h want %h",
                                        want.row_index, o_data.c_col2, want.c_col2));
                    if (o_data.c_col3 !== want.c_col3)
                        report_mismatch($sformatf("row %0d c_col3 got %h want %h",
                                        want.row_index, o_data.c_col3, want.c_col3));
                    if (o_data.row_index !== want.row_index)
                        report_mismatch($sformatf("row_index got %0d want %0d",
                                        o_data.row_index, want.row_index));
                    if (o_data.last !== want.last)
                        report_mismatch($sformatf("row %0d last got %b want %b",
                                        want.row_index, o_data.last, want.last));
                end
            end
            i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: too long without a transfer on either channel
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb_matrix4x4_multiply failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
